// ===== rtl/ntc_pkg.sv =====
package ntc_pkg;

  localparam int CODE_W     = 12;
  localparam int CODE_MAX_W = 16;
  localparam int TOP_W      = 20;
  localparam int PROD_W     = CODE_MAX_W + TOP_W;
  localparam int RQ_W       = PROD_W + 16;
  localparam int TEMP_W     = 17;
  localparam int STAT_W     = 2;
  localparam int COEF_W     = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int NORM_W     = 64;
  localparam int LZ_W       = 6;
  localparam int MANT_W     = 31;
  localparam int FRAC_W     = 24;
  localparam int EXP_W      = 7;
  localparam int L_W        = EXP_W + FRAC_W;
  localparam int LSQ_W      = 36;
  localparam int LCU_W      = 41;
  localparam int D_W        = 64;
  localparam int DIV_W      = D_W - 1;
  localparam int Q5_W       = 20;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [EXP_W-1:0] EXP_BIAS = 7'd47;

  localparam logic signed [COEF_W-1:0] COEF_A_RST = 48'sd72724092000000;
  localparam logic signed [COEF_W-1:0] COEF_B_RST = 48'sd17138220000000;
  localparam logic signed [COEF_W-1:0] COEF_C_RST = 48'sd14549890000;

  // 5 * 2^44: reciprocal quotient would need more than Q5_W bits at or below this
  localparam logic signed [D_W-1:0] D_SMALL = 64'sd87960930222080;
  localparam logic [DIV_W-1:0] REM_START = 63'd87960930222080;

  localparam logic [Q5_W-1:0] Q5_LO  = 20'd21952;
  localparam logic [Q5_W-1:0] Q5_HI  = 20'd677312;
  localparam logic [Q5_W-1:0] RECIP5 = 20'd838861;

  localparam logic [TEMP_W-1:0] TEMP_MAX = 17'h0FFFF;
  localparam logic [TEMP_W-1:0] TEMP_MIN = 17'h10000;
  localparam logic [TEMP_W-1:0] TEMP_OFS = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A = 2'd0,
    REG_COEF_B = 2'd1,
    REG_COEF_C = 2'd2
  } ntc_reg_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_SAT     = 2'd2
  } ntc_status_t;

  typedef struct packed {
    logic            bad;
    logic [LZ_W-1:0] lz;
    logic            sat_hi;
    logic            sat_lo;
  } ntc_side_t;

endpackage

// ===== rtl/ntc_div_cell.sv =====
module ntc_div_cell #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 16,
  parameter int QUO_W = 52
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                v_in,
  input  ntc_pkg::ntc_side_t  side_in,
  input  logic [NUM_W-1:0]    num_in,
  input  logic [DEN_W-1:0]    den_in,
  input  logic [DEN_W-1:0]    rem_in,
  input  logic [QUO_W-1:0]    quo_in,
  output logic                v_out,
  output ntc_pkg::ntc_side_t  side_out,
  output logic [NUM_W-1:0]    num_out,
  output logic [DEN_W-1:0]    den_out,
  output logic [DEN_W-1:0]    rem_out,
  output logic [QUO_W-1:0]    quo_out
);

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           fits;

  // bring down the next numerator bit and try one subtract
  assign trial = {rem_in, num_in[NUM_W-1]};
  assign diff  = trial - {1'b0, den_in};
  assign fits  = trial >= {1'b0, den_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      num_out  <= {num_in[NUM_W-2:0], 1'b0};
      den_out  <= den_in;
      rem_out  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_out  <= {quo_in[QUO_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/ntc_norm_cell.sv =====
module ntc_norm_cell #(
  parameter int SH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           v_in,
  input  ntc_pkg::ntc_side_t             side_in,
  input  logic [ntc_pkg::NORM_W-1:0]     x_in,
  output logic                           v_out,
  output ntc_pkg::ntc_side_t             side_out,
  output logic [ntc_pkg::NORM_W-1:0]     x_out
);

  logic               top_zero;
  ntc_pkg::ntc_side_t side_next;

  assign top_zero = x_in[ntc_pkg::NORM_W-1 -: SH] == '0;

  always_comb begin
    side_next = side_in;
    if (top_zero) begin
      side_next.lz = side_in.lz | ntc_pkg::LZ_W'(SH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_next;
      if (top_zero) begin
        x_out <= x_in << SH;
      end else begin
        x_out <= x_in;
      end
    end
  end

endmodule

// ===== rtl/ntc_log_cell.sv =====
module ntc_log_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           v_in,
  input  ntc_pkg::ntc_side_t             side_in,
  input  logic [ntc_pkg::MANT_W-1:0]     y_in,
  input  logic [ntc_pkg::FRAC_W-1:0]     frac_in,
  output logic                           v_out,
  output ntc_pkg::ntc_side_t             side_out,
  output logic [ntc_pkg::MANT_W-1:0]     y_out,
  output logic [ntc_pkg::FRAC_W-1:0]     frac_out
);

  logic [2*ntc_pkg::MANT_W-1:0] sq;
  logic [ntc_pkg::MANT_W:0]     sq_q30;

  // mantissa in [1,2) as Q30; its square lands in [1,4)
  assign sq     = (2*ntc_pkg::MANT_W)'(y_in) * (2*ntc_pkg::MANT_W)'(y_in);
  assign sq_q30 = sq[2*ntc_pkg::MANT_W-1 -: ntc_pkg::MANT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      frac_out <= {frac_in[ntc_pkg::FRAC_W-2:0], sq_q30[ntc_pkg::MANT_W]};
      y_out    <= sq_q30[ntc_pkg::MANT_W] ? sq_q30[ntc_pkg::MANT_W:1]
                                          : sq_q30[ntc_pkg::MANT_W-1:0];
    end
  end

endmodule

// ===== rtl/ntc_poly.sv =====
module ntc_poly (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic signed [ntc_pkg::COEF_W-1:0]  coef_a,
  input  logic signed [ntc_pkg::COEF_W-1:0]  coef_b,
  input  logic signed [ntc_pkg::COEF_W-1:0]  coef_c,
  input  logic                               v_in,
  input  ntc_pkg::ntc_side_t                 side_in,
  input  logic signed [ntc_pkg::L_W-1:0]     l_in,
  output logic                               v_out,
  output ntc_pkg::ntc_side_t                 side_out,
  output logic signed [ntc_pkg::D_W-1:0]     d_out
);

  localparam int P_BL  = ntc_pkg::COEF_W + ntc_pkg::L_W;
  localparam int P_LL  = 2 * ntc_pkg::L_W;
  localparam int P_LC  = ntc_pkg::LSQ_W + ntc_pkg::L_W;
  localparam int P_C   = ntc_pkg::COEF_W + ntc_pkg::LCU_W;
  localparam int LHI_W = ntc_pkg::L_W - 16;
  localparam int CTP_W = ntc_pkg::LCU_W - 32;
  localparam logic signed [P_C-1:0] C_LIM = {{(P_C-62){1'b0}}, 1'b1, 61'b0};

  logic               v   [7];
  ntc_pkg::ntc_side_t sd  [7];

  // stage 1: L^2 and low half of B*L
  logic signed [P_LL-1:0]          ll;
  logic signed [16:0]              l_lo;
  logic signed [P_BL-1:0]          bl_lo;
  logic signed [ntc_pkg::LSQ_W-1:0] lsq1;
  logic signed [P_BL-1:0]          bl1;
  logic signed [ntc_pkg::L_W-1:0]  l1;

  assign ll    = l_in * l_in;
  assign l_lo  = $signed({1'b0, l_in[15:0]});
  assign bl_lo = coef_b * l_lo;

  // stage 2: finish B*L, low half of L^3
  logic signed [LHI_W-1:0]         l1_hi;
  logic signed [16:0]              l1_lo;
  logic signed [P_BL-1:0]          bl_hi;
  logic signed [P_BL-1:0]          bl_sum;
  logic signed [P_BL-1:0]          bl_sh;
  logic signed [P_LC-1:0]          lc_lo;
  logic signed [ntc_pkg::D_W-1:0]  bl2;
  logic signed [P_LC-1:0]          lc2;
  logic signed [ntc_pkg::LSQ_W-1:0] lsq2;
  logic signed [LHI_W-1:0]         l2_hi;

  assign l1_hi  = $signed(l1[ntc_pkg::L_W-1:16]);
  assign l1_lo  = $signed({1'b0, l1[15:0]});
  assign bl_hi  = coef_b * l1_hi;
  assign bl_sum = bl1 + (bl_hi <<< 16);
  assign bl_sh  = bl_sum >>> 24;
  assign lc_lo  = lsq1 * l1_lo;

  // stage 3: finish L^3
  logic signed [P_LC-1:0]           lc_hi;
  logic signed [P_LC-1:0]           lc_sum;
  logic signed [P_LC-1:0]           lc_sh;
  logic signed [ntc_pkg::LCU_W-1:0] lcu3;
  logic signed [ntc_pkg::D_W-1:0]   bl3;

  assign lc_hi  = lsq2 * l2_hi;
  assign lc_sum = lc2 + (lc_hi <<< 16);
  assign lc_sh  = lc_sum >>> 24;

  // stages 4 to 6: C*L^3 in three slices of L^3 (16, 16 and 9 bits)
  logic signed [16:0]               c_ch0;
  logic signed [16:0]               c_ch1;
  logic signed [CTP_W-1:0]          c_ch2;
  logic signed [P_C-1:0]            cp0;
  logic signed [P_C-1:0]            cp1;
  logic signed [P_C-1:0]            cp2;
  logic signed [P_C-1:0]            c4;
  logic signed [P_C-1:0]            c5;
  logic signed [P_C-1:0]            c_full;
  logic signed [P_C-1:0]            c_sh;
  logic signed [ntc_pkg::LCU_W-1:0] lcu4;
  logic signed [ntc_pkg::LCU_W-1:0] lcu5;
  logic signed [ntc_pkg::D_W-1:0]   bl4;
  logic signed [ntc_pkg::D_W-1:0]   bl5;
  logic signed [ntc_pkg::D_W-1:0]   bl6;
  logic signed [ntc_pkg::D_W-1:0]   cl6;
  logic signed [ntc_pkg::D_W-1:0]   c_clamp;
  logic signed [ntc_pkg::D_W-1:0]   a_ext;

  assign c_ch0  = $signed({1'b0, lcu3[15:0]});
  assign c_ch1  = $signed({1'b0, lcu4[31:16]});
  assign c_ch2  = $signed(lcu5[ntc_pkg::LCU_W-1:32]);
  assign cp0    = coef_c * c_ch0;
  assign cp1    = coef_c * c_ch1;
  assign cp2    = coef_c * c_ch2;
  assign c_full = c5 + (cp2 <<< 32);
  assign c_sh   = c_full >>> 24;

  // term is clamped to +-2^61, so the sum below cannot overflow
  always_comb begin
    if (c_sh > C_LIM) begin
      c_clamp = C_LIM[ntc_pkg::D_W-1:0];
    end else if (c_sh < -C_LIM) begin
      c_clamp = -(C_LIM[ntc_pkg::D_W-1:0]);
    end else begin
      c_clamp = c_sh[ntc_pkg::D_W-1:0];
    end
  end

  assign a_ext = {{(ntc_pkg::D_W-ntc_pkg::COEF_W){coef_a[ntc_pkg::COEF_W-1]}}, coef_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 7; i++) begin
        v[i] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= v_in;
      for (int i = 1; i < 7; i++) begin
        v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side_in;
      for (int i = 1; i < 7; i++) begin
        sd[i] <= sd[i-1];
      end
      lsq1  <= ll[ntc_pkg::LSQ_W+23:24];
      bl1   <= bl_lo;
      l1    <= l_in;
      bl2   <= bl_sh[ntc_pkg::D_W-1:0];
      lc2   <= lc_lo;
      lsq2  <= lsq1;
      l2_hi <= l1_hi;
      lcu3  <= lc_sh[ntc_pkg::LCU_W-1:0];
      bl3   <= bl2;
      c4    <= cp0;
      lcu4  <= lcu3;
      bl4   <= bl3;
      c5    <= c4 + (cp1 <<< 16);
      lcu5  <= lcu4;
      bl5   <= bl4;
      cl6   <= c_clamp;
      bl6   <= bl5;
      d_out <= a_ext + bl6 + cl6;
    end
  end

  assign v_out    = v[6];
  assign side_out = sd[6];

endmodule

// ===== rtl/ntc_steinhart_hart_temperature.sv =====
// NTC thermistor temperature by the Steinhart-Hart equation. Each 12-bit ADC
// word from the divider gives one result word: degrees Celsius in 1/256 degree
// (signed, saturated) and a status (0 valid, 1 open/short thermistor,
// 2 saturated). One word is accepted every cycle while the output is not
// stalled. The pipeline runs through the 52 restoring-divider cells that
// form the resistance, the 6 normalize cells and 24 squaring cells of the
// logarithm, the 7-stage polynomial, and the 20 reciprocal-divider cells.
// A result that waits at the output holds the whole pipeline, so the input
// stalls with it until the result is taken. Write the coefficients only while
// no word is in flight. No clearing pass after reset.
module ntc_steinhart_hart_temperature #(
  parameter int ADC_BITS        = 12,
  parameter int FULL_SCALE      = 4095,
  parameter int TOP_RES_OHMS    = 10000,
  parameter int SERIES_RES_OHMS = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ntc_pkg::CODE_W-1:0]        adc_code,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ntc_pkg::TEMP_W-1:0]        temperature,
  output logic [ntc_pkg::STAT_W-1:0]        status,
  input  logic                              cfg_wr_en,
  input  logic [ntc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ntc_pkg::COEF_W-1:0]        cfg_data
);

  localparam int CW = ntc_pkg::CODE_MAX_W;
  localparam int RQ = ntc_pkg::RQ_W;
  localparam int NW = ntc_pkg::NORM_W;
  localparam int FW = ntc_pkg::FRAC_W;
  localparam int QW = ntc_pkg::Q5_W;
  localparam int DV = ntc_pkg::DIV_W;
  localparam logic [CW-1:0] CODE_MASK = CW'((32'd1 << ADC_BITS) - 32'd1);
  localparam logic [CW-1:0] FS = CW'(FULL_SCALE);
  localparam logic [RQ-1:0] SERIES_Q16 = RQ'(SERIES_RES_OHMS) << 16;

  logic en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // coefficient registers
  logic signed [ntc_pkg::COEF_W-1:0] coef_a;
  logic signed [ntc_pkg::COEF_W-1:0] coef_b;
  logic signed [ntc_pkg::COEF_W-1:0] coef_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= ntc_pkg::COEF_A_RST;
      coef_b <= ntc_pkg::COEF_B_RST;
      coef_c <= ntc_pkg::COEF_C_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == ntc_pkg::REG_COEF_A) begin
        coef_a <= cfg_data;
      end
      if (cfg_index == ntc_pkg::REG_COEF_B) begin
        coef_b <= cfg_data;
      end
      if (cfg_index == ntc_pkg::REG_COEF_C) begin
        coef_c <= cfg_data;
      end
    end
  end

  // input stage: numerator code*TOP in Q16, denominator FS-code
  logic [CW-1:0]                  code;
  logic [ntc_pkg::PROD_W-1:0]     prod;
  logic                           s0_v;
  ntc_pkg::ntc_side_t             s0_side_next;
  ntc_pkg::ntc_side_t             s0_side;
  logic [RQ-1:0]                  s0_num;
  logic [CW-1:0]                  s0_den;

  assign code = {{(CW-ntc_pkg::CODE_W){1'b0}}, adc_code} & CODE_MASK;
  assign prod = ntc_pkg::PROD_W'(code) * ntc_pkg::PROD_W'(TOP_RES_OHMS);

  always_comb begin
    s0_side_next     = '0;
    s0_side_next.bad = code >= FS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side <= s0_side_next;
      s0_num  <= {prod, 16'b0};
      s0_den  <= FS - code;
    end
  end

  // resistance divider
  logic               d1_v    [RQ+1];
  ntc_pkg::ntc_side_t d1_side [RQ+1];
  logic [RQ-1:0]      d1_num  [RQ+1];
  logic [CW-1:0]      d1_den  [RQ+1];
  logic [CW-1:0]      d1_rem  [RQ+1];
  logic [RQ-1:0]      d1_quo  [RQ+1];

  assign d1_v[0]    = s0_v;
  assign d1_side[0] = s0_side;
  assign d1_num[0]  = s0_num;
  assign d1_den[0]  = s0_den;
  assign d1_rem[0]  = '0;
  assign d1_quo[0]  = '0;

  for (genvar i = 0; i < RQ; i++) begin : g_div1
    ntc_div_cell #(
      .NUM_W(RQ),
      .DEN_W(CW),
      .QUO_W(RQ)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .v_in    (d1_v[i]),
      .side_in (d1_side[i]),
      .num_in  (d1_num[i]),
      .den_in  (d1_den[i]),
      .rem_in  (d1_rem[i]),
      .quo_in  (d1_quo[i]),
      .v_out   (d1_v[i+1]),
      .side_out(d1_side[i+1]),
      .num_out (d1_num[i+1]),
      .den_out (d1_den[i+1]),
      .rem_out (d1_rem[i+1]),
      .quo_out (d1_quo[i+1])
    );
  end

  // series resistance removal
  logic               s1_v;
  ntc_pkg::ntc_side_t s1_side_next;
  ntc_pkg::ntc_side_t s1_side;
  logic [NW-1:0]      s1_x;

  always_comb begin
    s1_side_next     = d1_side[RQ];
    s1_side_next.bad = d1_side[RQ].bad || (d1_quo[RQ] <= SERIES_Q16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= d1_v[RQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side <= s1_side_next;
      s1_x    <= {{(NW-RQ){1'b0}}, d1_quo[RQ] - SERIES_Q16};
    end
  end

  // leading-zero normalize, halves first
  logic               nm_v    [ntc_pkg::LZ_W+1];
  ntc_pkg::ntc_side_t nm_side [ntc_pkg::LZ_W+1];
  logic [NW-1:0]      nm_x    [ntc_pkg::LZ_W+1];

  assign nm_v[0]    = s1_v;
  assign nm_side[0] = s1_side;
  assign nm_x[0]    = s1_x;

  for (genvar k = 0; k < ntc_pkg::LZ_W; k++) begin : g_norm
    ntc_norm_cell #(
      .SH(1 << (ntc_pkg::LZ_W - 1 - k))
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .v_in    (nm_v[k]),
      .side_in (nm_side[k]),
      .x_in    (nm_x[k]),
      .v_out   (nm_v[k+1]),
      .side_out(nm_side[k+1]),
      .x_out   (nm_x[k+1])
    );
  end

  // log2 fraction by repeated squaring
  logic                         lg_v    [FW+1];
  ntc_pkg::ntc_side_t           lg_side [FW+1];
  logic [ntc_pkg::MANT_W-1:0]   lg_y    [FW+1];
  logic [FW-1:0]                lg_frac [FW+1];

  assign lg_v[0]    = nm_v[ntc_pkg::LZ_W];
  assign lg_side[0] = nm_side[ntc_pkg::LZ_W];
  assign lg_y[0]    = nm_x[ntc_pkg::LZ_W][NW-1 -: ntc_pkg::MANT_W];
  assign lg_frac[0] = '0;

  for (genvar j = 0; j < FW; j++) begin : g_log
    ntc_log_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .v_in    (lg_v[j]),
      .side_in (lg_side[j]),
      .y_in    (lg_y[j]),
      .frac_in (lg_frac[j]),
      .v_out   (lg_v[j+1]),
      .side_out(lg_side[j+1]),
      .y_out   (lg_y[j+1]),
      .frac_out(lg_frac[j+1])
    );
  end

  // ln = log2 * ln2, floored
  logic [ntc_pkg::EXP_W-1:0]       ex;
  logic signed [ntc_pkg::L_W-1:0]  l2;
  logic signed [63:0]              ln_prod;
  logic                            sl_v;
  ntc_pkg::ntc_side_t              sl_side;
  logic signed [ntc_pkg::L_W-1:0]  sl_l;

  assign ex      = ntc_pkg::EXP_BIAS - {1'b0, lg_side[FW].lz};
  assign l2      = $signed({ex, lg_frac[FW]});
  assign ln_prod = l2 * $signed({1'b0, ntc_pkg::LN2_Q32});

  always_ff @(posedge clk) begin
    if (rst) begin
      sl_v <= 1'b0;
    end else if (en) begin
      sl_v <= lg_v[FW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sl_side <= lg_side[FW];
      sl_l    <= ln_prod[ntc_pkg::L_W+31:32];
    end
  end

  // denominator A + B*L + C*L^3
  logic                            py_v;
  ntc_pkg::ntc_side_t              py_side;
  logic signed [ntc_pkg::D_W-1:0]  py_d;

  ntc_poly u_poly (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .coef_a  (coef_a),
    .coef_b  (coef_b),
    .coef_c  (coef_c),
    .v_in    (sl_v),
    .side_in (sl_side),
    .l_in    (sl_l),
    .v_out   (py_v),
    .side_out(py_side),
    .d_out   (py_d)
  );

  // reciprocal: 5*2^64/D, only the low Q5_W quotient bits are needed
  logic               d2_v    [QW+1];
  ntc_pkg::ntc_side_t d2_side [QW+1];
  logic [QW-1:0]      d2_num  [QW+1];
  logic [DV-1:0]      d2_den  [QW+1];
  logic [DV-1:0]      d2_rem  [QW+1];
  logic [QW-1:0]      d2_quo  [QW+1];
  ntc_pkg::ntc_side_t py_side_next;

  always_comb begin
    py_side_next        = py_side;
    py_side_next.sat_lo = py_d < 0;
    py_side_next.sat_hi = (py_d == 0) || ((py_d > 0) && (py_d <= ntc_pkg::D_SMALL));
  end

  assign d2_side[0] = py_side_next;
  assign d2_v[0]    = py_v;
  assign d2_num[0]  = '0;
  assign d2_den[0]  = py_d[DV-1:0];
  assign d2_rem[0]  = ntc_pkg::REM_START;
  assign d2_quo[0]  = '0;

  for (genvar i = 0; i < QW; i++) begin : g_div2
    ntc_div_cell #(
      .NUM_W(QW),
      .DEN_W(DV),
      .QUO_W(QW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .v_in    (d2_v[i]),
      .side_in (d2_side[i]),
      .num_in  (d2_num[i]),
      .den_in  (d2_den[i]),
      .rem_in  (d2_rem[i]),
      .quo_in  (d2_quo[i]),
      .v_out   (d2_v[i+1]),
      .side_out(d2_side[i+1]),
      .num_out (d2_num[i+1]),
      .den_out (d2_den[i+1]),
      .rem_out (d2_rem[i+1]),
      .quo_out (d2_quo[i+1])
    );
  end

  // temperature = floor((q5 - 273.15*256*5) / 5), divide by 5 via reciprocal
  logic [QW-1:0]                 q5;
  logic [QW-1:0]                 q5_ofs;
  logic [2*QW-1:0]               div5;
  logic [ntc_pkg::TEMP_W-1:0]    t_lin;
  logic [ntc_pkg::TEMP_W-1:0]    temp_next;
  ntc_pkg::ntc_status_t          status_next;
  ntc_pkg::ntc_status_t          status_q;
  ntc_pkg::ntc_side_t            fin_side;

  assign q5       = d2_quo[QW];
  assign fin_side = d2_side[QW];
  assign q5_ofs   = q5 - ntc_pkg::Q5_LO;
  assign div5     = (2*QW)'(q5_ofs) * (2*QW)'(ntc_pkg::RECIP5);
  assign t_lin    = div5[22 +: ntc_pkg::TEMP_W] - ntc_pkg::TEMP_OFS;

  always_comb begin
    if (fin_side.bad) begin
      temp_next   = '0;
      status_next = ntc_pkg::ST_INVALID;
    end else if (fin_side.sat_lo) begin
      temp_next   = ntc_pkg::TEMP_MIN;
      status_next = ntc_pkg::ST_SAT;
    end else if (fin_side.sat_hi || (q5 >= ntc_pkg::Q5_HI)) begin
      temp_next   = ntc_pkg::TEMP_MAX;
      status_next = ntc_pkg::ST_SAT;
    end else if (q5 < ntc_pkg::Q5_LO) begin
      temp_next   = ntc_pkg::TEMP_MIN;
      status_next = ntc_pkg::ST_SAT;
    end else begin
      temp_next   = t_lin;
      status_next = ntc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d2_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temperature <= temp_next;
      status_q    <= status_next;
    end
  end

  assign status = status_q;

endmodule
